// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the lexer modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/exl_pkg.sv =====
`default_nettype none
package exl_pkg;

  // Token kinds as they appear on the result channel.
  localparam logic [4:0] K_INT    = 5'd0;
  localparam logic [4:0] K_LE     = 5'd1;
  localparam logic [4:0] K_GE     = 5'd2;
  localparam logic [4:0] K_GT     = 5'd3;
  localparam logic [4:0] K_LT     = 5'd4;
  localparam logic [4:0] K_NE     = 5'd5;
  localparam logic [4:0] K_EQ     = 5'd6;
  localparam logic [4:0] K_NOT    = 5'd7;
  localparam logic [4:0] K_AND    = 5'd8;
  localparam logic [4:0] K_OR     = 5'd9;
  localparam logic [4:0] K_PLUS   = 5'd10;
  localparam logic [4:0] K_MINUS  = 5'd11;
  localparam logic [4:0] K_UMINUS = 5'd12;
  localparam logic [4:0] K_MUL    = 5'd13;
  localparam logic [4:0] K_DIV    = 5'd14;
  localparam logic [4:0] K_LPAREN = 5'd15;
  localparam logic [4:0] K_RPAREN = 5'd16;
  localparam logic [4:0] K_EOF    = 5'd17;
  localparam logic [4:0] K_ERROR  = 5'd18;

  // One result item.
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic        ovf;
    logic        last;
  } tok_t;

  // Results produced by one input item: count and up to two slots.
  typedef struct packed {
    logic [1:0] n;
    tok_t       s0;
    tok_t       s1;
  } push_t;

  // Build a token with no value.
  function automatic tok_t mk_op(logic [4:0] kind, logic last);
    tok_t t;
    t.kind  = kind;
    t.value = 32'd0;
    t.ovf   = 1'b0;
    t.last  = last;
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/exl_core.sv =====
`default_nettype none
module exl_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   ch,
  input  wire logic         eot,
  output exl_pkg::push_t    push
);

`include "assert_macros.svh"

  // Pending token codes.
  localparam logic [2:0] P_NONE = 3'd0;
  localparam logic [2:0] P_INT  = 3'd1;
  localparam logic [2:0] P_LT   = 3'd2;
  localparam logic [2:0] P_GT   = 3'd3;
  localparam logic [2:0] P_BANG = 3'd4;
  localparam logic [2:0] P_EQ   = 3'd5;
  localparam logic [2:0] P_AMP  = 3'd6;
  localparam logic [2:0] P_BAR  = 3'd7;

  // Characters of interest.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  localparam int WW = VALUE_WIDTH + 4;
  localparam logic [VALUE_WIDTH-1:0] VMAX = {VALUE_WIDTH{1'b1}};

  logic [2:0]             pend_r, pend_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   unary_r, unary_nxt;
  logic                   halted_r, halted_nxt;

  logic [WW-1:0]          acc_ext;
  logic [WW-1:0]          acc_mac;
  logic                   is_digit;
  logic [VALUE_WIDTH-1:0] dig;
  exl_pkg::tok_t          slot [2];
  logic [1:0]             n;
  logic                   go;
  logic                   pair;
  logic [4:0]             pair_kind;
  exl_pkg::tok_t          itok;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= P_NONE;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      unary_r  <= 1'b1;
      halted_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      unary_r  <= unary_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Decimal accumulate: acc * 10 + digit, as shifts and adds.
  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign dig      = VALUE_WIDTH'(ch - CH_0);
  assign acc_ext  = WW'(acc_r);
  assign acc_mac  = (acc_ext << 3) + (acc_ext << 1) + WW'(dig);

  // Two-character operator match against the pending prefix.
  always_comb begin
    pair      = 1'b1;
    pair_kind = exl_pkg::K_LE;
    priority if (pend_r == P_LT && ch == CH_EQ)    pair_kind = exl_pkg::K_LE;
    else if (pend_r == P_GT && ch == CH_EQ)        pair_kind = exl_pkg::K_GE;
    else if (pend_r == P_BANG && ch == CH_EQ)      pair_kind = exl_pkg::K_NE;
    else if (pend_r == P_EQ && ch == CH_EQ)        pair_kind = exl_pkg::K_EQ;
    else if (pend_r == P_AMP && ch == CH_AMP)      pair_kind = exl_pkg::K_AND;
    else if (pend_r == P_BAR && ch == CH_BAR)      pair_kind = exl_pkg::K_OR;
    else                                           pair = 1'b0;
  end

  // The pending integer as a result item.
  always_comb begin
    itok       = exl_pkg::mk_op(exl_pkg::K_INT, 1'b0);
    itok.value = 32'(acc_r);
    itok.ovf   = ovf_r;
  end

  // One lexing step: next state and up to two result items.
  always_comb begin
    pend_nxt   = pend_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    unary_nxt  = unary_r;
    halted_nxt = halted_r;
    slot[0]    = '0;
    slot[1]    = '0;
    n          = 2'd0;
    go         = 1'b0;
    if (step) begin
      if (eot) begin
        // End of text: unless halted, flush, then EOF unless a lone operator is an error.
        if (!halted_r) begin
          go = 1'b1;
          if (pend_r == P_INT) begin
            slot[0] = itok;
            n       = 2'd1;
          end else if (pend_r == P_LT) begin
            slot[0] = exl_pkg::mk_op(exl_pkg::K_LT, 1'b0);
            n       = 2'd1;
          end else if (pend_r == P_GT) begin
            slot[0] = exl_pkg::mk_op(exl_pkg::K_GT, 1'b0);
            n       = 2'd1;
          end else if (pend_r == P_BANG) begin
            slot[0] = exl_pkg::mk_op(exl_pkg::K_NOT, 1'b0);
            n       = 2'd1;
          end else if (pend_r != P_NONE) begin
            slot[0] = exl_pkg::mk_op(exl_pkg::K_ERROR, 1'b1);
            n       = 2'd1;
            go      = 1'b0;
          end
          if (go) begin
            slot[n[0]] = exl_pkg::mk_op(exl_pkg::K_EOF, 1'b1);
            n          = n + 2'd1;
          end
        end
        pend_nxt   = P_NONE;
        acc_nxt    = '0;
        ovf_nxt    = 1'b0;
        unary_nxt  = 1'b1;
        halted_nxt = 1'b0;
      end else if (!halted_r) begin
        go = 1'b1;
        if (pend_r == P_INT) begin
          if (is_digit) begin
            // Extend the number, saturating on overflow.
            go = 1'b0;
            if (ovf_r || (acc_mac > WW'(VMAX))) begin
              acc_nxt = VMAX;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_mac[VALUE_WIDTH-1:0];
            end
          end else begin
            slot[0]   = itok;
            n         = 2'd1;
            unary_nxt = 1'b0;
            pend_nxt  = P_NONE;
            acc_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end else if (pend_r != P_NONE) begin
          pend_nxt = P_NONE;
          if (pair) begin
            slot[0]   = exl_pkg::mk_op(pair_kind, 1'b0);
            n         = 2'd1;
            unary_nxt = 1'b1;
            go        = 1'b0;
          end else if (pend_r == P_LT) begin
            slot[0]   = exl_pkg::mk_op(exl_pkg::K_LT, 1'b0);
            n         = 2'd1;
            unary_nxt = 1'b1;
          end else if (pend_r == P_GT) begin
            slot[0]   = exl_pkg::mk_op(exl_pkg::K_GT, 1'b0);
            n         = 2'd1;
            unary_nxt = 1'b1;
          end else if (pend_r == P_BANG) begin
            slot[0]   = exl_pkg::mk_op(exl_pkg::K_NOT, 1'b0);
            n         = 2'd1;
            unary_nxt = 1'b1;
          end else begin
            // A lone '=', '&' or '|' is an error; the character is consumed.
            slot[0]    = exl_pkg::mk_op(exl_pkg::K_ERROR, 1'b1);
            n          = 2'd1;
            halted_nxt = 1'b1;
            go         = 1'b0;
          end
        end
        // Start of a fresh token.
        if (go) begin
          if (ch == CH_SPACE || ch == CH_TAB) begin
            // Whitespace is skipped.
          end else if (ch == CH_0) begin
            slot[n[0]] = exl_pkg::mk_op(exl_pkg::K_INT, 1'b0);
            n          = n + 2'd1;
            unary_nxt  = 1'b0;
          end else if (ch >= CH_1 && ch <= CH_9) begin
            pend_nxt = P_INT;
            acc_nxt  = dig;
            ovf_nxt  = 1'b0;
          end else begin
            unique case (ch)
              CH_LT:    pend_nxt = P_LT;
              CH_GT:    pend_nxt = P_GT;
              CH_BANG:  pend_nxt = P_BANG;
              CH_EQ:    pend_nxt = P_EQ;
              CH_AMP:   pend_nxt = P_AMP;
              CH_BAR:   pend_nxt = P_BAR;
              CH_PLUS: begin
                slot[n[0]] = exl_pkg::mk_op(exl_pkg::K_PLUS, 1'b0);
                n          = n + 2'd1;
                unary_nxt  = 1'b1;
              end
              CH_MINUS: begin
                slot[n[0]] = exl_pkg::mk_op(
                  unary_nxt ? exl_pkg::K_UMINUS : exl_pkg::K_MINUS, 1'b0);
                n          = n + 2'd1;
                unary_nxt  = 1'b1;
              end
              CH_STAR: begin
                slot[n[0]] = exl_pkg::mk_op(exl_pkg::K_MUL, 1'b0);
                n          = n + 2'd1;
                unary_nxt  = 1'b1;
              end
              CH_SLASH: begin
                slot[n[0]] = exl_pkg::mk_op(exl_pkg::K_DIV, 1'b0);
                n          = n + 2'd1;
                unary_nxt  = 1'b1;
              end
              CH_LPAR: begin
                slot[n[0]] = exl_pkg::mk_op(exl_pkg::K_LPAREN, 1'b0);
                n          = n + 2'd1;
                unary_nxt  = 1'b1;
              end
              CH_RPAR: begin
                slot[n[0]] = exl_pkg::mk_op(exl_pkg::K_RPAREN, 1'b0);
                n          = n + 2'd1;
                unary_nxt  = 1'b1;
              end
              default: begin
                // Unknown character: error, then ignore until end of text.
                slot[n[0]] = exl_pkg::mk_op(exl_pkg::K_ERROR, 1'b1);
                n          = n + 2'd1;
                halted_nxt = 1'b1;
              end
            endcase
          end
        end
      end
    end
  end

  assign push.n  = n;
  assign push.s0 = slot[0];
  assign push.s1 = slot[1];

  // While halted nothing can be pending.
  `ASSERT_IMPL(a_halt_idle, halted_r, pend_r == P_NONE)
  // Accumulator and overflow flag are live only inside a number.
  `ASSERT_IMPL(a_acc_clear, pend_r != P_INT, acc_r == '0 && !ovf_r)
  // Saturation is sticky while the number continues.
  `ASSERT_NEXT(a_ovf_sticky, ovf_r && pend_r == P_INT && step && !eot && is_digit,
               ovf_r && acc_r == VMAX)

endmodule
`default_nettype wire

// ===== hw/rtl/exl_outq.sv =====
`default_nettype none
module exl_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire exl_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output exl_pkg::tok_t       out_tok
);

`include "assert_macros.svh"

  localparam int DEPTH = 4;

  exl_pkg::tok_t q_r [DEPTH];
  logic [1:0]    wr_r, wr_nxt;
  logic [1:0]    rd_r, rd_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          pop;
  logic [1:0]    wr_p1;

  // Room for the worst case of two results from one item.
  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_tok   = q_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign wr_p1     = wr_r + 2'd1;

  // Pointer and fill-level update.
  always_comb begin
    wr_nxt  = wr_r + push.n;
    rd_nxt  = pop ? rd_r + 2'd1 : rd_r;
    cnt_nxt = cnt_r + 3'(push.n) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_r] <= push.s0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_p1] <= push.s1;
    end
  end

  // Fill level stays within the queue.
  `ASSERT_IMPL(a_cnt_max, 1'b1, cnt_r <= 3'(DEPTH))
  // Results are only pushed when two slots are free.
  `ASSERT_IMPL(a_push_room, push.n != 2'd0, room)
  // A stalled head item is not dropped.
  `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && rd_r == $past(rd_r))

endmodule
`default_nettype wire

// ===== hw/rtl/expression_lexer.sv =====
// Channel  Ports                         Contents
// in       in_tvalid/tready/tdata/tlast  tdata[7:0] ch; tlast end_of_text
// out      out_tvalid/tready/tdata/tlast tdata[4:0] kind, [36:5] value,
//                                        [37] overflow; tlast last
//
// Each item is captured in the input register and, once the queue has
// room, lexed by combinational logic into a four-entry result queue that
// registers its results. One item is accepted per cycle while the queue
// holds at most two results; an item that yields two results takes two
// queue entries. Reset (synchronous, rst_n low) clears the lexer state and
// empties the queue.
`default_nettype none
module expression_lexer #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [4:0] token_kind, [36:5] int_value,
                                       // [37] overflow, [39:38] zero
  output logic             out_tlast   // last
);

  logic           vld_r;
  logic [7:0]     ch_r;
  logic           eot_r;
  logic           room;
  logic           step;
  exl_pkg::push_t push;
  exl_pkg::tok_t  tok;

  // Input register; it drains whenever the queue has room.
  assign step      = vld_r && room;
  assign in_tready = !vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r  <= in_tdata;
      eot_r <= in_tlast;
    end
  end

  exl_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .ch   (ch_r),
    .eot  (eot_r),
    .push (push)
  );

  exl_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_tok  (tok)
  );

  // Pack the head result.
  assign out_tdata = {2'b00, tok.ovf, tok.value, tok.kind};
  assign out_tlast = tok.last;

endmodule
`default_nettype wire

// ===== sim/expression_lexer_tb.sv =====
`timescale 1ns / 100ps
module expression_lexer_tb;

  // What the lexer holds between characters while a token is incomplete.
  typedef enum logic [2:0] {
    PEND_NONE,
    PEND_INT,
    PEND_LT,
    PEND_GT,
    PEND_BANG,
    PEND_EQ,
    PEND_AMP,
    PEND_BAR
  } pend_e;

  // One row of the directed text. A typed_n of -1 leaves the expected tokens
  // to the lexer model; otherwise k0 and k1 give the first typed_n kinds.
  typedef struct {
    logic [7:0] ch;
    logic       eot;
    int         typed_n;
    logic [4:0] k0;
    logic [4:0] k1;
  } row_t;

  localparam logic [31:0] VALUE_MAX     = 32'hFFFF_FFFF;
  localparam int          ITEM_TARGET   = 1700;
  localparam int          MAX_WAIT      = 7;
  localparam int          SETTLE_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  // Lexer model state.
  pend_e       pend;
  logic [31:0] acc;
  logic        acc_ovf;
  logic        minus_unary;
  logic        halted;

  exl_pkg::tok_t tokens_due[$];
  row_t          text_rows[$];
  int            fail_count;
  int            items_done;
  int            expr_count;
  logic          steady;

  expression_lexer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Return the model to the start of an expression.
  function automatic void clear_lexer();
    pend        = PEND_NONE;
    acc         = '0;
    acc_ovf     = 1'b0;
    minus_unary = 1'b1;
    halted      = 1'b0;
  endfunction

  // Queue one expected token and track whether a following minus is unary.
  function automatic void note_token(logic [4:0] kind, logic [31:0] value, logic ovf,
                                     logic last);
    exl_pkg::tok_t t;
    t.kind  = kind;
    t.value = value;
    t.ovf   = ovf;
    t.last  = last;
    tokens_due.push_back(t);
    if (kind != exl_pkg::K_ERROR && kind != exl_pkg::K_EOF) begin
      minus_unary = (kind != exl_pkg::K_INT);
    end
  endfunction

  function automatic void note_error();
    note_token(exl_pkg::K_ERROR, '0, 1'b0, 1'b1);
    pend   = PEND_NONE;
    halted = 1'b1;
  endfunction

  // Emit a pending single-character operator; a lone '=', '&' or '|' is an error.
  function automatic logic flush_op(pend_e p);
    case (p)
      PEND_LT:   note_token(exl_pkg::K_LT, '0, 1'b0, 1'b0);
      PEND_GT:   note_token(exl_pkg::K_GT, '0, 1'b0, 1'b0);
      PEND_BANG: note_token(exl_pkg::K_NOT, '0, 1'b0, 1'b0);
      PEND_EQ, PEND_AMP, PEND_BAR: begin
        note_error();
        return 1'b0;
      end
      default: ;
    endcase
    pend = PEND_NONE;
    return 1'b1;
  endfunction

  // A character seen with nothing pending.
  function automatic void start_token(logic [7:0] c);
    if (c == " " || c == "\t") begin
      return;
    end
    if (c == "0") begin
      note_token(exl_pkg::K_INT, '0, 1'b0, 1'b0);
      return;
    end
    if (c >= "1" && c <= "9") begin
      pend    = PEND_INT;
      acc     = 32'(c - "0");
      acc_ovf = 1'b0;
      return;
    end
    case (c)
      "<": pend = PEND_LT;
      ">": pend = PEND_GT;
      "!": pend = PEND_BANG;
      "=": pend = PEND_EQ;
      "&": pend = PEND_AMP;
      "|": pend = PEND_BAR;
      "+": note_token(exl_pkg::K_PLUS, '0, 1'b0, 1'b0);
      "-": note_token(minus_unary ? exl_pkg::K_UMINUS : exl_pkg::K_MINUS,
                      '0, 1'b0, 1'b0);
      "*": note_token(exl_pkg::K_MUL, '0, 1'b0, 1'b0);
      "/": note_token(exl_pkg::K_DIV, '0, 1'b0, 1'b0);
      "(": note_token(exl_pkg::K_LPAREN, '0, 1'b0, 1'b0);
      ")": note_token(exl_pkg::K_RPAREN, '0, 1'b0, 1'b0);
      default: note_error();
    endcase
  endfunction

  // Work out the tokens that one accepted character causes.
  function automatic void lex_char(logic [7:0] c, logic eot);
    logic        ok;
    logic [31:0] d;
    logic [4:0]  k;
    logic        pair;
    if (eot) begin
      if (!halted) begin
        ok = 1'b1;
        if (pend == PEND_INT) begin
          note_token(exl_pkg::K_INT, acc, acc_ovf, 1'b0);
        end else if (pend != PEND_NONE) begin
          ok = flush_op(pend);
        end
        if (ok) begin
          note_token(exl_pkg::K_EOF, '0, 1'b0, 1'b1);
        end
      end
      clear_lexer();
      return;
    end
    if (halted) begin
      return;
    end

    if (pend == PEND_INT) begin
      // Digits extend the number, saturating at the top of the value range.
      if (c >= "0" && c <= "9") begin
        d = 32'(c - "0");
        if (acc_ovf || acc > (VALUE_MAX - d) / 10) begin
          acc     = VALUE_MAX;
          acc_ovf = 1'b1;
        end else begin
          acc = acc * 10 + d;
        end
        return;
      end
      note_token(exl_pkg::K_INT, acc, acc_ovf, 1'b0);
      pend    = PEND_NONE;
      acc     = '0;
      acc_ovf = 1'b0;
    end else if (pend != PEND_NONE) begin
      // Prefer the two-character operator where the pair matches.
      pair = 1'b1;
      k    = exl_pkg::K_INT;
      if (pend == PEND_LT && c == "=") k = exl_pkg::K_LE;
      else if (pend == PEND_GT && c == "=") k = exl_pkg::K_GE;
      else if (pend == PEND_BANG && c == "=") k = exl_pkg::K_NE;
      else if (pend == PEND_EQ && c == "=") k = exl_pkg::K_EQ;
      else if (pend == PEND_AMP && c == "&") k = exl_pkg::K_AND;
      else if (pend == PEND_BAR && c == "|") k = exl_pkg::K_OR;
      else pair = 1'b0;
      if (pair) begin
        pend = PEND_NONE;
        note_token(k, '0, 1'b0, 1'b0);
        return;
      end
      if (!flush_op(pend)) begin
        return;
      end
    end
    start_token(c);
  endfunction

  function automatic void add_row(logic [7:0] ch, logic eot, int typed_n,
                                  logic [4:0] k0 = exl_pkg::K_INT,
                                  logic [4:0] k1 = exl_pkg::K_INT);
    row_t r;
    r.ch      = ch;
    r.eot     = eot;
    r.typed_n = typed_n;
    r.k0      = k0;
    r.k1      = k1;
    text_rows.push_back(r);
  endfunction

  // Present one item after a random gap (none in steady mode), note its tokens, and wait for acceptance.
  task automatic send_item(logic [7:0] ch, logic eot, int typed_n, logic [4:0] k0,
                           logic [4:0] k1);
    int            gap;
    int            base;
    logic [4:0]    kinds[2];
    exl_pkg::tok_t t;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tdata  = ch;
    in_tlast  = eot;
    in_tvalid = 1'b1;
    items_done++;
    base = tokens_due.size();
    lex_char(ch, eot);
    // Rows with typed tokens replace what the model worked out.
    if (typed_n >= 0) begin
      while (tokens_due.size() > base) void'(tokens_due.pop_back());
      kinds[0] = k0;
      kinds[1] = k1;
      for (int i = 0; i < typed_n; i++) begin
        t.kind  = kinds[i];
        t.value = '0;
        t.ovf   = 1'b0;
        t.last  = (kinds[i] == exl_pkg::K_EOF || kinds[i] == exl_pkg::K_ERROR);
        tokens_due.push_back(t);
      end
    end
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Stop sending and wait until every expected token has come out.
  task automatic await_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
  endtask

  // One random expression: mostly well-formed pieces, some lone operators and
  // stray bytes, closed by end of text.
  task automatic send_expression();
    logic [7:0] text[$];
    string      ops;
    string      num;
    logic [7:0] c;
    int         r;
    int         len;
    ops = "<>!=&|+-*/()";
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // Numbers right at the saturation boundary.
        num = (r < 2) ? "4294967295" : "4294967296";
        for (int i = 0; i < num.len(); i++) text.push_back(num[i]);
      end else if (r < 40) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
        repeat (len) text.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (r < 80) begin
        c = ops[$urandom_range(0, 11)];
        text.push_back(c);
        case (c)
          "<", ">", "!": if ($urandom_range(0, 1) != 0) text.push_back("=");
          "=":           if ($urandom_range(0, 9) != 0) text.push_back("=");
          "&", "|":      if ($urandom_range(0, 9) != 0) text.push_back(c);
          default: ;
        endcase
      end else if (r < 92) begin
        text.push_back(($urandom_range(0, 1) != 0) ? " " : "\t");
      end else begin
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (text[i]) send_item(text[i], 1'b0, -1, exl_pkg::K_INT, exl_pkg::K_INT);
    send_item(8'($urandom_range(0, 255)), 1'b1, -1, exl_pkg::K_INT, exl_pkg::K_INT);
  endtask

  // Result side: random stalls before each token (none in steady mode).
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        @(negedge clk);
        out_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // Compare each token that leaves the block with the oldest one expected.
  always @(posedge clk) begin : check_tokens
    exl_pkg::tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected token: token_kind %0d", out_tdata[4:0]);
        fail_count++;
      end else begin
        want = tokens_due.pop_front();
        if (out_tdata[4:0] !== want.kind) begin
          $error("token_kind: expected %0d, actual %0d", want.kind, out_tdata[4:0]);
          fail_count++;
        end
        if (out_tdata[36:5] !== want.value) begin
          $error("int_value: expected %0d, actual %0d", want.value, out_tdata[36:5]);
          fail_count++;
        end
        if (out_tdata[37] !== want.ovf) begin
          $error("overflow: expected %0b, actual %0b", want.ovf, out_tdata[37]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed text, random expressions, drain.
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    steady     = 1'b0;
    fail_count = 0;
    items_done = 0;
    expr_count = 0;
    clear_lexer();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // End of text straight after reset gives a bare EOF.
    add_row(8'h00, 1'b1, 1, exl_pkg::K_EOF);
    // Unary minus at the start, a lone zero, then binary minus after an integer.
    add_row("-", 1'b0, -1);
    add_row("0", 1'b0, 1, exl_pkg::K_INT);
    add_row("-", 1'b0, -1);
    // Every operator, with two-character ones preferred over their prefix.
    add_row("<", 1'b0, -1);
    add_row("=", 1'b0, -1);
    add_row(">", 1'b0, -1);
    add_row(">", 1'b0, -1);
    add_row("=", 1'b0, -1);
    add_row("!", 1'b0, -1);
    add_row("=", 1'b0, -1);
    add_row("=", 1'b0, -1);
    add_row("=", 1'b0, -1);
    add_row("&", 1'b0, -1);
    add_row("&", 1'b0, -1);
    add_row("|", 1'b0, -1);
    add_row("|", 1'b0, -1);
    add_row("!", 1'b0, -1);
    add_row("(", 1'b0, -1);
    add_row("+", 1'b0, -1);
    add_row("*", 1'b0, -1);
    add_row("/", 1'b0, -1);
    add_row(")", 1'b0, -1);
    // Unknown byte flushes the pending '<' and halts; input is then ignored.
    add_row("<", 1'b0, -1);
    add_row(8'h00, 1'b0, 2, exl_pkg::K_LT, exl_pkg::K_ERROR);
    add_row(8'hFF, 1'b0, 0);
    add_row(8'hFF, 1'b1, 0);
    // Lone bar at end of text is an error with no EOF.
    add_row("|", 1'b0, -1);
    add_row("|", 1'b1, 1, exl_pkg::K_ERROR);

    foreach (text_rows[i]) begin
      send_item(text_rows[i].ch, text_rows[i].eot, text_rows[i].typed_n,
                text_rows[i].k0, text_rows[i].k1);
    end
    await_drain();

    while (items_done < ITEM_TARGET) begin
      steady = ($urandom_range(0, 7) == 0);
      send_expression();
      expr_count++;
      if (expr_count % 25 == 0) begin
        await_drain();
      end
    end

    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
